// File: hdl/bspg_pkg.sv
`default_nettype none

package bspg_pkg;

   localparam int CountW = 32;
   localparam int BinW   = 10;
   localparam int LetterW = 5;

   localparam logic [7:0] NewlineByte = 8'h0A;
   localparam logic [7:0] CaseBit     = 8'h20;
   localparam logic [7:0] UpperFirst  = 8'h41;
   localparam logic [7:0] UpperLast   = 8'h5A;
   localparam logic [7:0] DoubleQuote = 8'h22;
   localparam logic [7:0] Apostrophe  = 8'h27;
   localparam logic [7:0] Colon       = 8'h3A;
   localparam logic [7:0] Semicolon   = 8'h3B;

   localparam logic OpText = 1'b0;
   localparam logic OpRead = 1'b1;

   typedef logic [LetterW-1:0] letter_type;
   typedef logic [BinW-1:0]    bin_type;
   typedef logic [CountW-1:0]  count_type;

   localparam count_type SatMax = '1;

   // one item between the decode stage and the update stage
   typedef struct packed {
      logic      valid;
      logic      rd;
      logic      rd_ok;
      logic      adj_wr;
      logic      skip_wr;
      bin_type   adj_bin;
      bin_type   skip_bin;
      count_type adj_total;
      count_type skip_total;
   } stage_type;

   // result item, lowest field last so it packs straight onto tdata
   typedef struct packed {
      count_type skip_total;
      count_type adj_total;
      count_type skip_count;
      count_type adj_count;
   } result_type;

   // {hit, index} for the alphabet "etoainshrlduymwcgf.pb,vk'jx;zq"
   function automatic logic [LetterW:0] letter_of(input logic [7:0] b);
      logic [7:0]         c;
      logic [LetterW:0]   r;
      c = b;
      if (c >= UpperFirst && c <= UpperLast) begin
         c = c | CaseBit;
      end else if (c == DoubleQuote) begin
         c = Apostrophe;
      end else if (c == Colon) begin
         c = Semicolon;
      end
      unique case (c)
         8'h65: r = {1'b1, 5'd0};
         8'h74: r = {1'b1, 5'd1};
         8'h6F: r = {1'b1, 5'd2};
         8'h61: r = {1'b1, 5'd3};
         8'h69: r = {1'b1, 5'd4};
         8'h6E: r = {1'b1, 5'd5};
         8'h73: r = {1'b1, 5'd6};
         8'h68: r = {1'b1, 5'd7};
         8'h72: r = {1'b1, 5'd8};
         8'h6C: r = {1'b1, 5'd9};
         8'h64: r = {1'b1, 5'd10};
         8'h75: r = {1'b1, 5'd11};
         8'h79: r = {1'b1, 5'd12};
         8'h6D: r = {1'b1, 5'd13};
         8'h77: r = {1'b1, 5'd14};
         8'h63: r = {1'b1, 5'd15};
         8'h67: r = {1'b1, 5'd16};
         8'h66: r = {1'b1, 5'd17};
         8'h2E: r = {1'b1, 5'd18};
         8'h70: r = {1'b1, 5'd19};
         8'h62: r = {1'b1, 5'd20};
         8'h2C: r = {1'b1, 5'd21};
         8'h76: r = {1'b1, 5'd22};
         8'h6B: r = {1'b1, 5'd23};
         8'h27: r = {1'b1, 5'd24};
         8'h6A: r = {1'b1, 5'd25};
         8'h78: r = {1'b1, 5'd26};
         8'h3B: r = {1'b1, 5'd27};
         8'h7A: r = {1'b1, 5'd28};
         8'h71: r = {1'b1, 5'd29};
         default: r = '0;
      endcase
      return r;
   endfunction

   // unordered pair: low letter in the upper bits, 31 - high in the lower bits
   function automatic bin_type pair_bin(input letter_type a, input letter_type b);
      letter_type hi;
      letter_type lo;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      return {lo, ~hi};
   endfunction

   function automatic count_type sat_inc(input count_type v);
      return (v == SatMax) ? v : v + count_type'(1);
   endfunction

endpackage

`default_nettype wire

// File: hdl/bigram_skipgram_pair_histogram_top.sv
`default_nettype none

// channel   dir  signals                      payload
// req       in   req_tvalid/tready/tdata/tuser  text byte, bin index, operation
// rsp       out  rsp_tvalid/tready/tdata        two bin counts, two totals
//
// one transfer per cycle while no clearing pass runs and rsp keeps up; a response passes
// the stage register (decode + bin read), then the update stage and result queue
// the bin counters sit in two BIN_COUNT x 32 memories, read in the accept cycle and
// written back in the cycle after; the last write is forwarded to a following read
// after reset a clearing pass zeroes every address of both memories, with
// req_tready low
// a two-entry result queue absorbs rsp stalls; req_tready drops during the clearing
// pass and when the queue and the update stage together hold two items and none leaves

module bigram_skipgram_pair_histogram_top
   import bspg_pkg::*;
#(
   parameter int BIN_COUNT = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,   // [7:0] text_byte, [17:8] bin_index, zero pad
   input  wire logic         req_tuser,   // [0] operation: text byte or bin read
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata    // bigram_count, skipgram_count,
                                          // bigram_total, skipgram_total
);

   localparam int AddrW = $clog2(BIN_COUNT);

   logic              accept;
   logic              pop;
   stage_type         stage_next;
   stage_type         stage;
   count_type         adj_rdata;
   count_type         skip_rdata;
   logic              adj_we;
   logic [AddrW-1:0]  adj_waddr;
   count_type         adj_wdata;
   logic              skip_we;
   logic [AddrW-1:0]  skip_waddr;
   count_type         skip_wdata;
   logic              clear_busy;
   logic              result_valid;
   result_type        result;
   result_type        head_data;
   logic [1:0]        queue_count;
   logic [2:0]        in_flight;

   // items that still need a queue slot: queued plus one in the update stage
   assign in_flight  = {1'b0, queue_count} + 3'(stage.valid);
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = !clear_busy && ((in_flight < 3'd2) || pop);
   assign accept     = req_tvalid && req_tready;

   // decode, pair bins, letter history and totals
   bspg_front #(
      .BIN_COUNT (BIN_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (req_tuser),
      .text_byte  (req_tdata[7:0]),
      .bin_index  (req_tdata[17:8]),
      .stage_next (stage_next),
      .stage      (stage)
   );

   // bin reads are issued in the accept cycle
   bspg_ram #(
      .Width (CountW),
      .Depth (BIN_COUNT)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_addr (stage_next.adj_bin[AddrW-1:0]),
      .rd_data (adj_rdata)
   );

   bspg_ram #(
      .Width (CountW),
      .Depth (BIN_COUNT)
   ) u_skip_ram (
      .clock   (clock),
      .wr_en   (skip_we),
      .wr_addr (skip_waddr),
      .wr_data (skip_wdata),
      .rd_addr (stage_next.skip_bin[AddrW-1:0]),
      .rd_data (skip_rdata)
   );

   // saturating increment, write back with forwarding, clearing pass
   bspg_update #(
      .BIN_COUNT (BIN_COUNT)
   ) u_update (
      .clock        (clock),
      .reset        (reset),
      .stage        (stage),
      .adj_rdata    (adj_rdata),
      .skip_rdata   (skip_rdata),
      .adj_we       (adj_we),
      .adj_waddr    (adj_waddr),
      .adj_wdata    (adj_wdata),
      .skip_we      (skip_we),
      .skip_waddr   (skip_waddr),
      .skip_wdata   (skip_wdata),
      .clear_busy   (clear_busy),
      .result_valid (result_valid),
      .result       (result)
   );

   // result queue parting the response side from the pipeline
   bspg_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_data  (result),
      .pop        (pop),
      .head_valid (rsp_tvalid),
      .head_data  (head_data),
      .count      (queue_count)
   );

   assign rsp_tdata = head_data;

   // the update stage never holds an item while the memories are being cleared
   assert property (@(posedge clock) disable iff (reset)
      !(stage.valid && clear_busy))
      else $error("item in update stage during clearing pass");

   // the queue plus the update stage never hold more than two items
   assert property (@(posedge clock) disable iff (reset)
      in_flight <= 3'd2)
      else $error("result queue overrun");

   // a request accepted now reaches the update stage next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> stage.valid && (stage.rd == $past(req_tuser)))
      else $error("accepted request lost before update stage");

endmodule

`default_nettype wire

// File: hdl/bspg_ram.sv
`default_nettype none

module bspg_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read-first: a read at the write address returns the old word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/bspg_front.sv
`default_nettype none

module bspg_front
   import bspg_pkg::*;
#(
   parameter int BIN_COUNT = 1024
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       op,
   input  wire logic [7:0] text_byte,
   input  wire bin_type    bin_index,
   output stage_type       stage_next,
   output stage_type       stage
);

   localparam logic [BinW:0] BinLimit = (BinW+1)'(BIN_COUNT);

   letter_type          last_letter_ff, last_letter_in;
   logic                last_valid_ff, last_valid_in;
   letter_type          older_letter_ff, older_letter_in;
   logic                older_valid_ff, older_valid_in;
   count_type           adj_sum_ff, adj_sum_in;
   count_type           skip_sum_ff, skip_sum_in;
   stage_type           stage_ff, stage_in;

   logic                is_read;
   logic                is_text;
   logic [LetterW:0]    lookup;
   logic                hit;
   letter_type          cur;
   logic                count_adj;
   logic                count_skip;
   bin_type             adj_pair;
   bin_type             skip_pair;

   always_comb begin
      is_read    = (op == OpRead);
      is_text    = accept && !is_read && (text_byte != NewlineByte);
      lookup     = letter_of(text_byte);
      hit        = lookup[LetterW];
      cur        = lookup[LetterW-1:0];
      count_adj  = is_text && hit && last_valid_ff;
      count_skip = is_text && hit && older_valid_ff;
      adj_pair   = pair_bin(cur, last_letter_ff);
      skip_pair  = pair_bin(cur, older_letter_ff);

      adj_sum_in  = count_adj  ? sat_inc(adj_sum_ff)  : adj_sum_ff;
      skip_sum_in = count_skip ? sat_inc(skip_sum_ff) : skip_sum_ff;

      last_letter_in  = last_letter_ff;
      last_valid_in   = last_valid_ff;
      older_letter_in = older_letter_ff;
      older_valid_in  = older_valid_ff;
      if (accept && !is_read) begin
         if (text_byte == NewlineByte) begin
            last_valid_in  = 1'b0;
            older_valid_in = 1'b0;
         end else begin
            older_letter_in = last_letter_ff;
            older_valid_in  = last_valid_ff;
            last_valid_in   = hit;
            if (hit) begin
               last_letter_in = cur;
            end
         end
      end

      stage_in.valid      = accept;
      stage_in.rd         = is_read;
      stage_in.rd_ok      = ({1'b0, bin_index} < BinLimit);
      stage_in.adj_bin    = is_read ? bin_index : adj_pair;
      stage_in.skip_bin   = is_read ? bin_index : skip_pair;
      stage_in.adj_wr     = count_adj  && ({1'b0, adj_pair}  < BinLimit);
      stage_in.skip_wr    = count_skip && ({1'b0, skip_pair} < BinLimit);
      stage_in.adj_total  = adj_sum_in;
      stage_in.skip_total = skip_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_letter_ff  <= '0;
         last_valid_ff   <= 1'b0;
         older_letter_ff <= '0;
         older_valid_ff  <= 1'b0;
         adj_sum_ff      <= '0;
         skip_sum_ff     <= '0;
         stage_ff        <= '0;
      end else begin
         last_letter_ff  <= last_letter_in;
         last_valid_ff   <= last_valid_in;
         older_letter_ff <= older_letter_in;
         older_valid_ff  <= older_valid_in;
         adj_sum_ff      <= adj_sum_in;
         skip_sum_ff     <= skip_sum_in;
         stage_ff        <= stage_in;
      end
   end

   assign stage_next = stage_in;
   assign stage      = stage_ff;

endmodule

`default_nettype wire

// File: hdl/bspg_update.sv
`default_nettype none

module bspg_update
   import bspg_pkg::*;
#(
   parameter int BIN_COUNT = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire stage_type                    stage,
   input  wire count_type                    adj_rdata,
   input  wire count_type                    skip_rdata,
   output logic                              adj_we,
   output logic [$clog2(BIN_COUNT)-1:0]      adj_waddr,
   output count_type                         adj_wdata,
   output logic                              skip_we,
   output logic [$clog2(BIN_COUNT)-1:0]      skip_waddr,
   output count_type                         skip_wdata,
   output logic                              clear_busy,
   output logic                              result_valid,
   output result_type                        result
);

   localparam int AddrW = $clog2(BIN_COUNT);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(BIN_COUNT - 1);

   logic              clear_busy_ff, clear_busy_in;
   logic [AddrW-1:0]  clear_addr_ff, clear_addr_in;

   logic              fwd_adj_valid_ff, fwd_adj_valid_in;
   logic [AddrW-1:0]  fwd_adj_addr_ff, fwd_adj_addr_in;
   count_type         fwd_adj_data_ff, fwd_adj_data_in;
   logic              fwd_skip_valid_ff, fwd_skip_valid_in;
   logic [AddrW-1:0]  fwd_skip_addr_ff, fwd_skip_addr_in;
   count_type         fwd_skip_data_ff, fwd_skip_data_in;

   logic [AddrW-1:0]  adj_addr;
   logic [AddrW-1:0]  skip_addr;
   count_type         adj_cur;
   count_type         skip_cur;
   logic              adj_upd;
   logic              skip_upd;

   always_comb begin
      adj_addr  = stage.adj_bin[AddrW-1:0];
      skip_addr = stage.skip_bin[AddrW-1:0];

      // last cycle's write is not yet visible in the read data
      adj_cur  = (fwd_adj_valid_ff && fwd_adj_addr_ff == adj_addr)
                 ? fwd_adj_data_ff : adj_rdata;
      skip_cur = (fwd_skip_valid_ff && fwd_skip_addr_ff == skip_addr)
                 ? fwd_skip_data_ff : skip_rdata;

      adj_upd  = stage.valid && stage.adj_wr;
      skip_upd = stage.valid && stage.skip_wr;

      fwd_adj_valid_in  = adj_upd;
      fwd_adj_addr_in   = adj_addr;
      fwd_adj_data_in   = sat_inc(adj_cur);
      fwd_skip_valid_in = skip_upd;
      fwd_skip_addr_in  = skip_addr;
      fwd_skip_data_in  = sat_inc(skip_cur);

      clear_addr_in = clear_addr_ff;
      clear_busy_in = clear_busy_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + AddrW'(1);
         if (clear_addr_ff == LastAddr) begin
            clear_busy_in = 1'b0;
         end
      end

      if (clear_busy_ff) begin
         adj_we     = 1'b1;
         adj_waddr  = clear_addr_ff;
         adj_wdata  = '0;
         skip_we    = 1'b1;
         skip_waddr = clear_addr_ff;
         skip_wdata = '0;
      end else begin
         adj_we     = adj_upd;
         adj_waddr  = adj_addr;
         adj_wdata  = fwd_adj_data_in;
         skip_we    = skip_upd;
         skip_waddr = skip_addr;
         skip_wdata = fwd_skip_data_in;
      end

      result_valid      = stage.valid;
      result.adj_count  = (stage.rd && stage.rd_ok) ? adj_cur  : '0;
      result.skip_count = (stage.rd && stage.rd_ok) ? skip_cur : '0;
      result.adj_total  = stage.adj_total;
      result.skip_total = stage.skip_total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff     <= 1'b1;
         clear_addr_ff     <= '0;
         fwd_adj_valid_ff  <= 1'b0;
         fwd_skip_valid_ff <= 1'b0;
      end else begin
         clear_busy_ff     <= clear_busy_in;
         clear_addr_ff     <= clear_addr_in;
         fwd_adj_valid_ff  <= fwd_adj_valid_in;
         fwd_skip_valid_ff <= fwd_skip_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_adj_addr_ff  <= fwd_adj_addr_in;
      fwd_adj_data_ff  <= fwd_adj_data_in;
      fwd_skip_addr_ff <= fwd_skip_addr_in;
      fwd_skip_data_ff <= fwd_skip_data_in;
   end

   assign clear_busy = clear_busy_ff;

endmodule

`default_nettype wire

// File: hdl/bspg_outq.sv
`default_nettype none

module bspg_outq
   import bspg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   input  wire logic       pop,
   output logic            head_valid,
   output result_type      head_data,
   output logic [1:0]      count
);

   result_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

`default_nettype wire

// File: verif/tb_bigram_skipgram_pair_histogram_top.sv
module tb_bigram_skipgram_pair_histogram_top
   import bspg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // alphabet order of the letter ranks, first character in the top byte
   localparam int AlphaLen = 30;
   localparam logic [8*AlphaLen-1:0] Alphabet = "etoainshrlduymwcgf.pb,vk'jx;zq";
   localparam int BinDepth = 1024;

   localparam logic [7:0] LowerFirst     = UpperFirst | CaseBit;
   localparam logic [7:0] LowerLast      = UpperLast | CaseBit;
   localparam logic [7:0] NulByte        = 8'h00;
   localparam logic [7:0] CarriageReturn = 8'h0D;
   localparam logic [7:0] SpaceByte      = 8'h20;
   localparam logic [7:0] TopByte        = 8'hFF;

   // stream length and the receiver's long hold-off
   localparam int FeedItems  = 1750;
   localparam int HoldMark   = 400;
   localparam int HoldCycles = 120;

   // one pending request on the input stream
   typedef struct {
      logic       op;
      logic [7:0] ch;
      bin_type    idx;
      bit         drain;   // hold this one back until every result is in
   } feed_item_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata  = '0;      // [7:0] text_byte, [17:8] bin_index, zero pad
   logic         req_tuser  = OpText;  // [0] operation
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;            // bigram_count, skipgram_count,
                                       // bigram_total, skipgram_total

   bigram_skipgram_pair_histogram_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // expected histogram state, mirrored transfer by transfer
   letter_type prev_letter  = '0;
   bit         prev_ok      = 1'b0;
   letter_type prev2_letter = '0;
   bit         prev2_ok     = 1'b0;
   count_type  adj_hist [BinDepth];
   count_type  skip_hist [BinDepth];
   count_type  adj_total    = '0;
   count_type  skip_total   = '0;

   feed_item_type byte_feed [$];    // requests not yet offered
   result_type    counts_due [$];   // responses owed by the block, oldest first

   int mismatches = 0;
   int bytes_sent = 0;
   int reads_sent = 0;
   int hit_reads  = 0;
   int in_flight  = 0;
   int send_gap   = 0;
   int send_calm  = 0;
   int take_gap   = 0;
   int take_calm  = 0;
   int drained    = 0;
   int hold_left  = 0;
   bit held_off   = 1'b0;

   // rank of an accepted character after case folding, -1 for a rejected byte
   function automatic int char_rank(logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (c >= UpperFirst && c <= UpperLast) begin
         c = c | CaseBit;
      end else if (c == DoubleQuote) begin
         c = Apostrophe;
      end else if (c == Colon) begin
         c = Semicolon;
      end
      for (int i = 0; i < AlphaLen; i++) begin
         if (Alphabet[8*(AlphaLen-1-i) +: 8] == c) begin
            return i;
         end
      end
      return -1;
   endfunction

   // unordered pair bin: smaller rank in the upper five bits, 31 - larger below
   function automatic bin_type pair_index(int a, int b);
      int hi;
      int lo;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      return bin_type'(((31 - hi) & 31) | ((lo & 31) << 5));
   endfunction

   function automatic count_type bump(count_type v);
      return (v == SatMax) ? v : v + count_type'(1);
   endfunction

   // advance the expected state by one request and return the owed response
   function automatic result_type update_histogram(logic op, logic [7:0] ch, bin_type idx);
      result_type r;
      int         rank;
      bin_type    b;
      r = '0;
      if (op == OpRead) begin
         if (int'(idx) < BinDepth) begin
            r.adj_count  = adj_hist[idx];
            r.skip_count = skip_hist[idx];
         end
      end else if (ch == NewlineByte) begin
         prev_ok  = 1'b0;
         prev2_ok = 1'b0;
      end else begin
         rank = char_rank(ch);
         if (rank < 0) begin
            // rejected byte: breaks the bigram, last letter moves to the skip slot
            prev2_letter = prev_letter;
            prev2_ok     = prev_ok;
            prev_ok      = 1'b0;
         end else begin
            if (prev_ok) begin
               adj_total = bump(adj_total);
               b = pair_index(rank, prev_letter);
               adj_hist[b] = bump(adj_hist[b]);
            end
            if (prev2_ok) begin
               skip_total = bump(skip_total);
               b = pair_index(rank, prev2_letter);
               skip_hist[b] = bump(skip_hist[b]);
            end
            prev2_letter = prev_letter;
            prev2_ok     = prev_ok;
            prev_letter  = letter_type'(rank);
            prev_ok      = 1'b1;
         end
      end
      r.adj_total  = adj_total;
      r.skip_total = skip_total;
      return r;
   endfunction

   // mostly back-to-back, some short gaps, a few long ones, and calm stretches
   function automatic int pause_length(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // character of a rank, with random upper case and the quote/colon aliases
   function automatic logic [7:0] spell(int rank);
      logic [7:0] c;
      c = Alphabet[8*(AlphaLen-1-rank) +: 8];
      if (c >= LowerFirst && c <= LowerLast) begin
         if ($urandom_range(0, 3) == 0) c = c & ~CaseBit;
      end else if (c == Apostrophe) begin
         if ($urandom_range(0, 1) == 1) c = DoubleQuote;
      end else if (c == Semicolon) begin
         if ($urandom_range(0, 1) == 1) c = Colon;
      end
      return c;
   endfunction

   // the unused field of each request still carries random bits
   task automatic push_text(logic [7:0] ch);
      feed_item_type it;
      it = '{OpText, ch, bin_type'($urandom), 1'b0};
      byte_feed.insert(byte_feed.size(), it);
   endtask

   task automatic push_read(bin_type idx);
      feed_item_type it;
      it = '{OpRead, 8'($urandom), idx, 1'b0};
      byte_feed.insert(byte_feed.size(), it);
   endtask

   task automatic flag(string what, count_type want, count_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                  $realtime, what, want, want, got, got);
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // request driver: predicts each response at the moment its request transfers
   always @(posedge clock) begin : drive_req
      logic          fired;
      feed_item_type item;
      result_type    owed;
      if (reset) begin
         req_tvalid <= 1'b0;
         in_flight = 0;
      end else begin
         fired = req_tvalid && req_tready;
         if (fired) begin
            owed = update_histogram(req_tuser, req_tdata[7:0], req_tdata[17:8]);
            counts_due.insert(counts_due.size(), owed);
            in_flight++;
            if (req_tuser == OpRead) reads_sent++;
            else bytes_sent++;
         end
         // count responses from the sampled handshake, not from the checker's queue
         if (rsp_tvalid && rsp_tready) in_flight--;
         if (!req_tvalid || fired) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (byte_feed.size() != 0 && !(byte_feed[0].drain && in_flight != 0)) begin
               item = byte_feed.pop_front();
               req_tuser  <= item.op;
               req_tdata  <= {6'b0, item.idx, item.ch};
               req_tvalid <= 1'b1;
               send_gap = pause_length(send_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response sink: random stalls plus one long hold-off so the block backs up
   always @(posedge clock) begin : take_rsp
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) drained++;
         if (!held_off && drained >= HoldMark) begin
            held_off  = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            take_gap = pause_length(take_calm);
         end
      end
   end

   // response checker: every transfer against the oldest owed response
   always @(posedge clock) begin : check_rsp
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata);
         if (counts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response with none owed: 0x%032h", $realtime, rsp_tdata);
            end
         end else begin
            want = counts_due.pop_front();
            if (got.adj_count != want.adj_count) begin
               flag("bigram_count", want.adj_count, got.adj_count);
            end
            if (got.skip_count != want.skip_count) begin
               flag("skipgram_count", want.skip_count, got.skip_count);
            end
            if (got.adj_total != want.adj_total) begin
               flag("bigram_total", want.adj_total, got.adj_total);
            end
            if (got.skip_total != want.skip_total) begin
               flag("skipgram_total", want.skip_total, got.skip_total);
            end
         end
      end
   end

   // run limit, far beyond the slowest legal run including the clearing pass
   initial begin
      #2_000_000;
      $display("timeout with %0d responses still owed", counts_due.size());
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : main_flow
      int first_random;
      int wlen;
      int rank;
      int last_rank;
      int roll;
      int nreads;

      for (int i = 0; i < BinDepth; i++) begin
         adj_hist[i]  = '0;
         skip_hist[i] = '0;
      end

      // directed: empty store, doubled q, aliases, case edges, rejected bytes
      push_read('0);
      push_read('1);
      push_text("Q");
      push_text("q");          // same letter twice lands in the highest bin
      push_text(DoubleQuote);
      push_text(NewlineByte);  // both history slots cleared
      push_text("A");
      push_text(Colon);
      push_text(NulByte);      // rejected: skip pair still formed across it
      push_text("z");
      push_text(TopByte);
      push_text("Z");
      push_text(CarriageReturn);
      push_text(",");
      push_text(".");
      push_text("@");          // just outside the upper-case range
      push_text("[");
      push_text("e");
      push_read(pair_index(char_rank("q"), char_rank("q")));
      push_read(pair_index(char_rank("q"), char_rank("'")));
      push_read(pair_index(char_rank("a"), char_rank(";")));
      push_read(pair_index(char_rank("z"), char_rank("z")));
      push_read(pair_index(char_rank("."), char_rank(",")));
      push_read(pair_index(char_rank("e"), char_rank(".")));
      first_random = byte_feed.size();

      // random text: words of real characters, separators, and reads of live bins
      while (byte_feed.size() < first_random + FeedItems) begin
         wlen = $urandom_range(1, 8);
         last_rank = 0;
         for (int k = 0; k < wlen; k++) begin
            if (k > 0 && $urandom_range(0, 9) == 0) rank = last_rank;
            else rank = $urandom_range(0, AlphaLen - 1);
            push_text(spell(rank));
            last_rank = rank;
         end
         roll = $urandom_range(0, 99);
         if (roll < 55) push_text(SpaceByte);
         else if (roll < 70) push_text(NewlineByte);
         else if (roll < 85) push_text(8'($urandom));
         if ($urandom_range(0, 2) == 0) begin
            nreads = $urandom_range(1, 2);
            for (int k = 0; k < nreads; k++) begin
               if ($urandom_range(0, 9) < 7) begin
                  push_read(pair_index($urandom_range(0, AlphaLen - 1),
                                       $urandom_range(0, AlphaLen - 1)));
               end else begin
                  push_read(bin_type'($urandom));
               end
            end
         end
      end
      // sender waits for a full drain at the start of the random text and midway
      byte_feed[first_random].drain = 1'b1;
      byte_feed[first_random + FeedItems / 2].drain = 1'b1;

      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (byte_feed.size() != 0 || req_tvalid || counts_due.size() != 0);
      repeat (10) @(negedge clock);

      $display("run covered %0d text bytes and %0d bin reads, with %0d bigram and %0d skipgram",
               bytes_sent, reads_sent, adj_total, skip_total);
      $display("pairs counted, a %0d-cycle response hold-off and two full drains",
               HoldCycles);
      if (mismatches == 0 && counts_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
